FILE: src/sup_pkg.sv
`default_nettype none
package sup_pkg;
  localparam int FRAC_BITS = 12;
  localparam int NUM_FIELDS = 4;
  localparam logic signed [63:0] RES_MAX = 64'sd2147483647;
  localparam logic signed [63:0] RES_MIN = -64'sd2147483648;
  localparam logic signed [31:0] ONE_Q12 = 32'sd4096;

  typedef enum logic [2:0] {
    REG_MODE = 3'd0,
    REG_IN_COUNT = 3'd1,
    REG_OUT_COUNT = 3'd2,
    REG_WEIGHTS_0 = 3'd3,
    REG_WEIGHTS_1 = 3'd4,
    REG_WEIGHTS_2 = 3'd5,
    REG_WEIGHTS_3 = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ROUND = 2'd1,
    ST_SUB = 2'd2,
    ST_DONE = 2'd3
  } state_t;

  typedef struct packed {
    logic [7:0] unmixed_0;
    logic [7:0] unmixed_1;
    logic [7:0] unmixed_2;
    logic [7:0] unmixed_3;
    logic negative_seen;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > RES_MAX) r = RES_MAX[31:0];
    if (v < RES_MIN) r = RES_MIN[31:0];
    return r;
  endfunction

  function automatic logic [7:0] clamp_out(input logic signed [63:0] q);
    logic signed [63:0] v;
    logic [7:0] r;
    v = q >>> FRAC_BITS;
    if (q < 0) r = 8'd0;
    else if (v > 64'sd255) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: src/sup_if.sv
`default_nettype none
interface sup_in_if;
  logic valid;
  logic ready;
  logic [7:0] chan_in_0;
  logic [7:0] chan_in_1;
  logic [7:0] chan_in_2;
  logic [7:0] chan_in_3;
  modport source(output valid, chan_in_0, chan_in_1, chan_in_2, chan_in_3, input ready);
  modport sink(input valid, chan_in_0, chan_in_1, chan_in_2, chan_in_3, output ready);
endinterface

interface sup_out_if;
  logic valid;
  logic ready;
  logic [7:0] unmixed_0;
  logic [7:0] unmixed_1;
  logic [7:0] unmixed_2;
  logic [7:0] unmixed_3;
  logic negative_seen;
  modport source(output valid, unmixed_0, unmixed_1, unmixed_2, unmixed_3, negative_seen,
                 input ready);
  modport sink(input valid, unmixed_0, unmixed_1, unmixed_2, unmixed_3, negative_seen,
               output ready);
endinterface

interface sup_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/spectral_unmix_pixel_top.sv
`default_nettype none
// Per-pixel spectral unmixing of four 8-bit input channels into four 8-bit outputs.
// Channels: in (pixel beat), out (result beat), cfg (register index + 64-bit data).
// Four parallel dot-product lanes feed the outputs; in greedy mode a merge stage picks
// the channel for each round. Linear mode: the lane products are registered, clamped
// into the output registers, then loaded into the result register; a new pixel is taken
// only once the previous one has reached the result register and the block is idle.
// Greedy mode: each chosen round adds a project and a subtract step, up to one round
// per used input channel; the rounds share one lane bank.
// One pixel is computed at a time; in.ready is high while the block is idle.
// The result register holds its beat while out.ready is low; the next pixel is
// still taken and computed, then waits until the held beat leaves, and in.ready
// stays low meanwhile.
// Reset (synchronous, rst_n low): mode linear, counts 4, weights 0, no beat pending.
// Configuration is always ready and should only be written while idle.
module spectral_unmix_pixel_top import sup_pkg::*; #(
  parameter int IN_CHANNELS = 4,
  parameter int OUT_CHANNELS = 4,
  parameter int WEIGHT_BITS = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  sup_in_if.sink in_ch,
  sup_out_if.source out_ch,
  sup_cfg_if.sink cfg
);
  localparam int IN_LIM = IN_CHANNELS < NUM_FIELDS ? IN_CHANNELS : NUM_FIELDS;
  localparam int OUT_LIM = OUT_CHANNELS < NUM_FIELDS ? OUT_CHANNELS : NUM_FIELDS;

  logic mode_r;
  logic [2:0] in_count_r, out_count_r;
  logic [63:0] weights_r [NUM_FIELDS];
  state_t state_r, state_nxt;
  logic signed [31:0] vec_r [NUM_FIELDS];
  logic signed [31:0] vec_nxt [NUM_FIELDS];
  logic signed [63:0] acc [NUM_FIELDS];
  logic [7:0] outv_r [NUM_FIELDS];
  logic [7:0] outv_nxt [NUM_FIELDS];
  logic neg_r, neg_nxt;
  logic [2:0] round_r, round_nxt;
  result_t res_r, res_nxt;
  logic found, busy_r, busy_nxt;
  logic [1:0] pick;
  logic signed [31:0] best;
  logic [2:0] n_used, m_used;
  logic in_go;
  logic signed [31+WEIGHT_BITS:0] sub_prod;
  logic signed [63:0] sub;

  assign n_used = (in_count_r > 3'(IN_LIM)) ? 3'(IN_LIM) : in_count_r;
  assign m_used = (out_count_r > 3'(OUT_LIM)) ? 3'(OUT_LIM) : out_count_r;
  assign cfg.ready = 1'b1;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_go = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      in_count_r <= 3'd4;
      out_count_r <= 3'd4;
      for (int k = 0; k < NUM_FIELDS; k++) weights_r[k] <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MODE: mode_r <= cfg.data[0];
        REG_IN_COUNT: in_count_r <= cfg.data[2:0];
        REG_OUT_COUNT: out_count_r <= cfg.data[2:0];
        REG_WEIGHTS_0: weights_r[0] <= cfg.data;
        REG_WEIGHTS_1: weights_r[1] <= cfg.data;
        REG_WEIGHTS_2: weights_r[2] <= cfg.data;
        REG_WEIGHTS_3: weights_r[3] <= cfg.data;
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < NUM_FIELDS; k++) begin : g_lane
    sup_lane #(.WEIGHT_BITS(WEIGHT_BITS)) u_lane (
      .clk(clk), .weights(weights_r[k]), .n_used(n_used), .vec(vec_r), .acc_r(acc[k])
    );
  end

  sup_merge u_merge (.acc(acc), .m_used(m_used), .found(found), .pick(pick), .best(best));

  always_comb begin
    state_nxt = state_r;
    vec_nxt = vec_r;
    outv_nxt = outv_r;
    neg_nxt = neg_r;
    round_nxt = round_r;
    res_nxt = res_r;
    busy_nxt = busy_r;
    sub_prod = '0;
    sub = '0;
    if (out_ch.valid && out_ch.ready) busy_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_go) begin
          vec_nxt[0] = 32'(in_ch.chan_in_0);
          vec_nxt[1] = 32'(in_ch.chan_in_1);
          vec_nxt[2] = 32'(in_ch.chan_in_2);
          vec_nxt[3] = 32'(in_ch.chan_in_3);
          if (mode_r) for (int i = 0; i < NUM_FIELDS; i++) vec_nxt[i] = vec_nxt[i] <<< FRAC_BITS;
          round_nxt = '0;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        // lane results for vec_r are ready in the cycle after vec_r loads
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        if (!mode_r) begin
          neg_nxt = 1'b0;
          for (int k = 0; k < NUM_FIELDS; k++) begin
            outv_nxt[k] = '0;
            if (k < int'(m_used)) begin
              outv_nxt[k] = clamp_out(acc[k]);
              if (acc[k] < 0) neg_nxt = 1'b1;
            end
          end
          state_nxt = ST_DONE;
        end else begin
          if (round_r == '0) for (int k = 0; k < NUM_FIELDS; k++) outv_nxt[k] = '0;
          neg_nxt = 1'b0;
          if (round_r >= n_used || !found) begin
            state_nxt = ST_DONE;
          end else begin
            outv_nxt[pick] = clamp_out(64'(best));
            for (int i = 0; i < NUM_FIELDS; i++) begin
              if (i < int'(n_used)) begin
                sub_prod = best * signed'(weights_r[pick][i*WEIGHT_BITS +: WEIGHT_BITS]);
                sub = 64'(sub_prod >>> FRAC_BITS);
                if ((i + 1) * WEIGHT_BITS > 64) sub = '0;
                vec_nxt[i] = sat32(64'(vec_r[i]) - sub);
              end
            end
            round_nxt = round_r + 3'd1;
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_DONE: begin
        // wait here while the previous beat is still held
        if (!busy_r || (out_ch.valid && out_ch.ready)) begin
          busy_nxt = 1'b1;
          res_nxt.unmixed_0 = outv_r[0];
          res_nxt.unmixed_1 = outv_r[1];
          res_nxt.unmixed_2 = outv_r[2];
          res_nxt.unmixed_3 = outv_r[3];
          res_nxt.negative_seen = neg_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r <= 1'b0;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      busy_r <= busy_nxt;
      round_r <= round_nxt;
    end
    vec_r <= vec_nxt;
    outv_r <= outv_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign out_ch.valid = busy_r;
  assign out_ch.unmixed_0 = res_r.unmixed_0;
  assign out_ch.unmixed_1 = res_r.unmixed_1;
  assign out_ch.unmixed_2 = res_r.unmixed_2;
  assign out_ch.unmixed_3 = res_r.unmixed_3;
  assign out_ch.negative_seen = res_r.negative_seen;
endmodule
`default_nettype wire

FILE: src/sup_lane.sv
`default_nettype none
// one output channel: dot product of weights with a 4-element vector, registered
module sup_lane import sup_pkg::*; #(
  parameter int WEIGHT_BITS = 16
) (
  input wire logic clk,
  input wire logic [63:0] weights,
  input wire logic [2:0] n_used,
  input wire logic signed [31:0] vec [NUM_FIELDS],
  output logic signed [63:0] acc_r
);
  localparam int SLOTS = 64 / WEIGHT_BITS;
  logic signed [31+WEIGHT_BITS:0] prod [NUM_FIELDS];
  logic signed [63:0] acc_nxt;

  always_comb begin
    acc_nxt = '0;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      prod[i] = '0;
      if (i < SLOTS && i < int'(n_used)) begin
        prod[i] = signed'(weights[i*WEIGHT_BITS +: WEIGHT_BITS]) * vec[i];
      end
      acc_nxt = acc_nxt + 64'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end
endmodule
`default_nettype wire

FILE: src/sup_merge.sv
`default_nettype none
// picks the largest projection above one, ties to the lowest channel
module sup_merge import sup_pkg::*; (
  input wire logic signed [63:0] acc [NUM_FIELDS],
  input wire logic [2:0] m_used,
  output logic found,
  output logic [1:0] pick,
  output logic signed [31:0] best
);
  logic signed [31:0] p;
  always_comb begin
    best = ONE_Q12;
    found = 1'b0;
    pick = '0;
    for (int k = 0; k < NUM_FIELDS; k++) begin
      p = sat32(acc[k] >>> FRAC_BITS);
      if (k < int'(m_used) && p > best) begin
        best = p;
        found = 1'b1;
        pick = 2'(k);
      end
    end
  end
endmodule
`default_nettype wire

FILE: dv/spectral_unmix_pixel_top_test.sv
module spectral_unmix_pixel_top_test;
  import sup_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  sup_in_if in_ch();
  sup_out_if out_ch();
  sup_cfg_if cfg();

  spectral_unmix_pixel_top i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  typedef struct {
    logic [7:0] px [4];
  } pixel_t;

  typedef struct {
    logic [7:0] unm [4];
    logic neg;
  } unmix_t;

  typedef struct {
    logic [7:0] px [4];
    logic check_fixed;
    logic [7:0] fx [4];
    logic fneg;
  } row_t;

  // shadow copy of the block's registers
  logic mdl_mode;
  logic [2:0] mdl_in_count;
  logic [2:0] mdl_out_count;
  logic [63:0] mdl_w [4];

  unmix_t expected_q[$];
  pixel_t send_q[$];
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;

  function automatic longint fshift(longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic longint sat_res(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [7:0] clamp8(longint q);
    longint v;
    v = fshift(q);
    if (q < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic longint wt(int k, int i);
    logic signed [15:0] f;
    f = mdl_w[k][i*16 +: 16];
    return longint'(f);
  endfunction

  function automatic unmix_t unmix_pixel(pixel_t p);
    unmix_t r;
    int n, m, pick;
    longint acc, best, pr, sub;
    longint res [4];
    n = mdl_in_count > 4 ? 4 : mdl_in_count;
    m = mdl_out_count > 4 ? 4 : mdl_out_count;
    for (int k = 0; k < 4; k++) r.unm[k] = 8'd0;
    r.neg = 1'b0;
    if (!mdl_mode) begin
      for (int k = 0; k < m; k++) begin
        acc = 0;
        for (int i = 0; i < n; i++) acc += wt(k, i) * longint'(p.px[i]);
        if (acc < 0) r.neg = 1'b1;
        r.unm[k] = clamp8(acc);
      end
      return r;
    end
    for (int i = 0; i < 4; i++) res[i] = longint'(p.px[i]) <<< FRAC_BITS;
    for (int rd = 0; rd < n; rd++) begin
      best = 4096;
      pick = -1;
      for (int k = 0; k < m; k++) begin
        acc = 0;
        for (int i = 0; i < n; i++) acc += wt(k, i) * res[i];
        pr = sat_res(fshift(acc));
        if (pr > best) begin
          best = pr;
          pick = k;
        end
      end
      if (pick < 0) break;
      r.unm[pick] = clamp8(best);
      for (int i = 0; i < n; i++) begin
        sub = fshift(best * wt(pick, i));
        res[i] = sat_res(res[i] - sub);
      end
    end
    return r;
  endfunction

  task automatic cfg_write(reg_idx_t idx, logic [63:0] d);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= d;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      REG_MODE: mdl_mode = d[0];
      REG_IN_COUNT: mdl_in_count = d[2:0];
      REG_OUT_COUNT: mdl_out_count = d[2:0];
      default: mdl_w[idx - REG_WEIGHTS_0] = d;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0 || send_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_config(logic mode, logic [2:0] ic, logic [2:0] oc,
                            logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                            logic [63:0] w3);
    drain();
    cfg_write(REG_MODE, {63'd0, mode});
    cfg_write(REG_IN_COUNT, {61'd0, ic});
    cfg_write(REG_OUT_COUNT, {61'd0, oc});
    cfg_write(REG_WEIGHTS_0, w0);
    cfg_write(REG_WEIGHTS_1, w1);
    cfg_write(REG_WEIGHTS_2, w2);
    cfg_write(REG_WEIGHTS_3, w3);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // small weights near unity so greedy rounds actually fire
  function automatic logic [63:0] fp_weights();
    logic [63:0] w;
    for (int i = 0; i < 4; i++) w[i*16 +: 16] = 16'($urandom_range(0, 6000)) - 16'd600;
    return w;
  endfunction

  function automatic pixel_t rnd_pixel();
    pixel_t p;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 5))
        0: p.px[i] = 8'd0;
        1: p.px[i] = 8'd255;
        default: p.px[i] = 8'($urandom);
      endcase
    end
    return p;
  endfunction

  // sender: pixels queued in send_q, predicted at acceptance
  initial begin
    pixel_t p;
    int gap;
    in_ch.valid = 1'b0;
    in_ch.chan_in_0 = 0; in_ch.chan_in_1 = 0; in_ch.chan_in_2 = 0; in_ch.chan_in_3 = 0;
    forever begin
      @(negedge clk);
      if (send_q.size() != 0) begin
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge clk);
        p = send_q[0];
        in_ch.valid <= 1'b1;
        in_ch.chan_in_0 <= p.px[0];
        in_ch.chan_in_1 <= p.px[1];
        in_ch.chan_in_2 <= p.px[2];
        in_ch.chan_in_3 <= p.px[3];
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        expected_q = {expected_q, unmix_pixel(p)};
        void'(send_q.pop_front());
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver with random stalls and an occasional long hold-off
  initial begin
    int st;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        hold_off--;
      end else begin
        st = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 19);
        if (st > 0) begin
          out_ch.ready <= 1'b0;
          repeat (st) @(negedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
        while (!out_ch.valid) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    unmix_t e;
    logic [7:0] got [4];
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got[0] = out_ch.unmixed_0; got[1] = out_ch.unmixed_1;
      got[2] = out_ch.unmixed_2; got[3] = out_ch.unmixed_3;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected beat", $time);
        errors++;
      end else begin
        e = expected_q.pop_front();
        for (int k = 0; k < 4; k++)
          if (got[k] !== e.unm[k]) begin
            $display("%0t unmixed_%0d exp %0d got %0d", $time, k, e.unm[k], got[k]);
            errors++;
          end
        if (out_ch.negative_seen !== e.neg) begin
          $display("%0t negative_seen exp %0b got %0b", $time, e.neg, out_ch.negative_seen);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  row_t dir_rows [$];

  task automatic add_row(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d,
                         logic fixed, logic [7:0] f0, logic [7:0] f1, logic [7:0] f2,
                         logic [7:0] f3, logic fn);
    row_t r;
    r.px[0] = a; r.px[1] = b; r.px[2] = c; r.px[3] = d;
    r.check_fixed = fixed;
    r.fx[0] = f0; r.fx[1] = f1; r.fx[2] = f2; r.fx[3] = f3;
    r.fneg = fn;
    dir_rows = {dir_rows, r};
  endtask

  task automatic run_rows();
    pixel_t p;
    unmix_t e;
    foreach (dir_rows[j]) begin
      p.px = dir_rows[j].px;
      if (dir_rows[j].check_fixed) begin
        e = unmix_pixel(p);
        if (e.unm != dir_rows[j].fx || e.neg != dir_rows[j].fneg) begin
          $display("%0t table row %0d disagrees with prediction", $time, j);
          errors++;
        end
      end
      send_q = {send_q, p};
    end
    dir_rows.delete();
  endtask

  initial begin
    int n;
    cfg.valid = 1'b0;
    cfg.index = REG_MODE;
    cfg.data = 64'd0;
    mdl_mode = 0; mdl_in_count = 4; mdl_out_count = 4;
    for (int k = 0; k < 4; k++) mdl_w[k] = 64'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // after reset: zero weights give zeros
    add_row(8'd255, 8'd255, 8'd255, 8'd255, 1, 0, 0, 0, 0, 0);
    add_row(8'd0, 8'd0, 8'd0, 8'd0, 1, 0, 0, 0, 0, 0);
    run_rows();

    // identity weights, linear
    set_config(0, 3'd4, 3'd4, 64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
               64'h0000_1000_0000_0000, 64'h1000_0000_0000_0000);
    add_row(8'd1, 8'd2, 8'd3, 8'd255, 1, 1, 2, 3, 255, 0);
    add_row(8'd255, 8'd0, 8'd128, 8'd7, 1, 255, 0, 128, 7, 0);
    run_rows();

    // negative and large weights: clamp low and high
    set_config(0, 3'd4, 3'd4, 64'h8000_8000_8000_8000, 64'h7fff_7fff_7fff_7fff,
               64'hffff_0000_0000_0001, 64'h0000_0000_0000_0000);
    add_row(8'd255, 8'd255, 8'd255, 8'd255, 1, 0, 255, 0, 0, 1);
    add_row(8'd0, 8'd0, 8'd0, 8'd0, 1, 0, 0, 0, 0, 0);
    add_row(8'd1, 8'd0, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0);
    run_rows();

    // counts out of range and zero
    set_config(0, 3'd7, 3'd7, 64'h1000_1000_1000_1000, 64'h1000_1000_1000_1000,
               64'h1000_1000_1000_1000, 64'h1000_1000_1000_1000);
    add_row(8'd10, 8'd20, 8'd30, 8'd40, 1, 100, 100, 100, 100, 0);
    run_rows();
    set_config(0, 3'd0, 3'd0, 64'h1000_1000_1000_1000, 64'h1000_1000_1000_1000,
               64'h1000_1000_1000_1000, 64'h1000_1000_1000_1000);
    add_row(8'd10, 8'd20, 8'd30, 8'd40, 1, 0, 0, 0, 0, 0);
    run_rows();
    set_config(0, 3'd1, 3'd2, 64'h1000_1000_1000_1000, 64'h1000_1000_1000_1000,
               64'h1000_1000_1000_1000, 64'h1000_1000_1000_1000);
    add_row(8'd10, 8'd20, 8'd30, 8'd40, 1, 10, 10, 0, 0, 0);
    run_rows();

    // greedy: identity fingerprints, channels never chosen, ties, no rounds
    set_config(1, 3'd4, 3'd4, 64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
               64'h0000_1000_0000_0000, 64'h1000_0000_0000_0000);
    add_row(8'd5, 8'd0, 8'd9, 8'd1, 1, 5, 0, 9, 0, 0);
    add_row(8'd200, 8'd200, 8'd200, 8'd200, 1, 200, 200, 200, 200, 0);
    add_row(8'd0, 8'd0, 8'd0, 8'd0, 1, 0, 0, 0, 0, 0);
    add_row(8'd255, 8'd1, 8'd2, 8'd255, 0, 0, 0, 0, 0, 0);
    run_rows();
    set_config(1, 3'd0, 3'd4, 64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
               64'h0000_1000_0000_0000, 64'h1000_0000_0000_0000);
    add_row(8'd5, 8'd6, 8'd7, 8'd8, 1, 0, 0, 0, 0, 0);
    run_rows();
    set_config(1, 3'd4, 3'd4, 64'h7fff_7fff_7fff_7fff, 64'h8000_8000_8000_8000,
               64'h7fff_8000_7fff_8000, 64'h1000_1000_1000_1000);
    add_row(8'd255, 8'd255, 8'd255, 8'd255, 0, 0, 0, 0, 0, 0);
    add_row(8'd255, 8'd0, 8'd255, 8'd0, 0, 0, 0, 0, 0, 0);
    run_rows();

    // long receiver hold-off while the sender keeps offering
    drain();
    hold_off = 300;
    for (int j = 0; j < 8; j++) send_q = {send_q, rnd_pixel()};

    // random phases
    for (int ph = 0; ph < 22; ph++) begin
      case (ph % 4)
        0: set_config(0, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                      rnd64(), rnd64(), rnd64(), rnd64());
        1: set_config(0, 3'($urandom_range(1, 4)), 3'($urandom_range(1, 4)),
                      fp_weights(), fp_weights(), fp_weights(), fp_weights());
        2: set_config(1, 3'($urandom_range(1, 4)), 3'($urandom_range(1, 4)),
                      fp_weights(), fp_weights(), fp_weights(), fp_weights());
        default: set_config(1, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                            rnd64(), rnd64(), rnd64(), rnd64());
      endcase
      n = 25;
      for (int j = 0; j < n; j++) send_q = {send_q, rnd_pixel()};
    end
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
